### hdl/gmig_pkg.sv
`timescale 1ns / 1ps

package gmig_pkg;

  // Widths fixed by the register map and the word layout.
  localparam int SIDE_W   = 9;    // grid_width / grid_height registers
  localparam int CELL_W   = 8;    // cell column and row counters
  localparam int VC_W     = 10;   // vertex row length, side + 1
  localparam int VTX_W    = 17;   // vertex index
  localparam int VAR_W    = 2;    // tile_variant register
  localparam int IDX_W    = 2;    // configuration register index
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;

  localparam int MAX_SIDE_DEFAULT = 256;
  localparam int QUEUE_DEPTH      = 2;   // power of two

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_TILE_VARIANT = 2'd2;

  // Stitching modes. The unused code acts as the edge mode.
  localparam logic [VAR_W-1:0] VARIANT_NORMAL = 2'd0;
  localparam logic [VAR_W-1:0] VARIANT_EDGE   = 2'd1;
  localparam logic [VAR_W-1:0] VARIANT_CORNER = 2'd2;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd2;

  typedef struct packed {
    logic [SIDE_W-1:0] grid_width;
    logic [SIDE_W-1:0] grid_height;
    logic [VAR_W-1:0]  tile_variant;
  } cfg_t;

  // One cell, as handed from the front to the back.
  typedef struct packed {
    logic [VTX_W-1:0] base;        // top-left vertex of the cell
    logic [VC_W-1:0]  row_len;     // vertices per grid row
    logic             left_merge;
    logic             top_merge;
    logic             last_cell;
  } cmd_t;

  // Triangle slots of a cell fan, named by the two outer corners.
  typedef enum logic [2:0] {
    S_GD = 3'd0,
    S_DA = 3'd1,
    S_AB = 3'd2,
    S_BC = 3'd3,
    S_CF = 3'd4,
    S_FI = 3'd5,
    S_IH = 3'd6,
    S_HG = 3'd7
  } slot_t;

endpackage

### hdl/grid_mesh_index_generator.sv
`timescale 1ns / 1ps

// Channel  Direction  Contents (lowest bit first)
// in       slave      tdata[0] restart, rest zero
// out      master     tdata: vertex_first, vertex_second, vertex_third (17 bits each);
//                     tlast last_in_cell; tuser last_in_grid
// cfg      write      cfg_index 0 grid_width, 1 grid_height, 2 tile_variant
//
// Each input word yields the six to eight triangles of one cell, one output word per
// cycle while the output is not stalled. Words are accepted back to back while
// the cell queue has room.
// Reset is synchronous and active low; it clears the walk position, the queue and the
// output valid, and loads the registers with a 2 by 2 normal grid.
// A stall on the output holds the back end; the front keeps accepting until the queue
// fills.

module grid_mesh_index_generator
  import gmig_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [0] restart
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [16:0] first, [33:17] second, [50:34] third
  output logic                   out_tlast,
  output logic                   out_tuser,   // [0] last_in_grid
  input  logic                   cfg_wr_en,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [SIDE_W-1:0]      cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t front_cmd, head_cmd;
  logic queue_full, head_valid, pop, take;

  // Register file; writes to the unused index are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:   cfg_nxt.grid_width   = cfg_wdata;
        REG_GRID_HEIGHT:  cfg_nxt.grid_height  = cfg_wdata;
        REG_TILE_VARIANT: cfg_nxt.tile_variant = cfg_wdata[VAR_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width   <= SIDE_RESET;
      cfg_r.grid_height  <= SIDE_RESET;
      cfg_r.tile_variant <= VARIANT_NORMAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !queue_full;
  assign take      = in_tvalid && !queue_full;

  // The front tracks the walk position and turns each word into a cell command.
  gmig_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .take   (take),
    .restart(in_tdata[0]),
    .cmd    (front_cmd)
  );

  gmig_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_cmd  (front_cmd),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  // The back walks one cell's fan into the output register, a triangle per unstalled cycle.
  gmig_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

### hdl/gmig_front.sv
`timescale 1ns / 1ps

module gmig_front
  import gmig_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic take,      // a word is accepted this cycle
  input  logic restart,
  output cmd_t cmd
);

  localparam int MAX_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W = (MAX_W > SIDE_W) ? MAX_W : SIDE_W;
  localparam logic [CMP_W-1:0] MAX_V = CMP_W'(MAX_SIDE);

  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] c;
    c = (v < SIDE_RESET) ? SIDE_RESET : v;
    if (CMP_W'(c) > MAX_V) begin
      c = SIDE_W'(MAX_V);
    end
    return {c[SIDE_W-1:1], 1'b0};
  endfunction

  logic [CELL_W-1:0] col_r, col_nxt;
  logic [CELL_W-1:0] row_r, row_nxt;

  logic [SIDE_W-1:0] w_eff, h_eff;
  logic [CELL_W-1:0] cols, rows;
  logic [CELL_W-1:0] col_use, row_use;
  logic [SIDE_W-1:0] x, y;
  logic [SIDE_W-1:0] col_inc, row_inc;
  logic [VC_W-1:0]   vc;
  logic [SIDE_W+VC_W-1:0] prod;
  logic              col_end, last_cell;

  assign w_eff = eff_side(cfg.grid_width);
  assign h_eff = eff_side(cfg.grid_height);
  assign cols  = w_eff[SIDE_W-1:1];
  assign rows  = h_eff[SIDE_W-1:1];

  always_comb begin
    if (restart || (col_r >= cols) || (row_r >= rows)) begin
      col_use = '0;
      row_use = '0;
    end else begin
      col_use = col_r;
      row_use = row_r;
    end
  end

  assign x       = {col_use, 1'b0};
  assign y       = {row_use, 1'b0};
  assign vc      = VC_W'(w_eff) + VC_W'(1);
  assign prod    = (SIDE_W+VC_W)'(y) * (SIDE_W+VC_W)'(vc);
  assign col_inc = SIDE_W'(col_use) + SIDE_W'(1);
  assign row_inc = SIDE_W'(row_use) + SIDE_W'(1);
  assign col_end = (col_inc >= SIDE_W'(cols));
  assign last_cell = (col_inc == SIDE_W'(cols)) && (row_inc == SIDE_W'(rows));

  always_comb begin
    cmd.base       = VTX_W'(prod) + VTX_W'(x);
    cmd.row_len    = vc;
    cmd.left_merge = (col_use == '0) && (cfg.tile_variant != VARIANT_NORMAL);
    cmd.top_merge  = (row_use == '0) && (cfg.tile_variant == VARIANT_CORNER);
    cmd.last_cell  = last_cell;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      priority if (last_cell) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_end) begin
        col_nxt = '0;
        row_nxt = row_inc[CELL_W-1:0];
      end else begin
        col_nxt = col_inc[CELL_W-1:0];
        row_nxt = row_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### hdl/gmig_queue.sv
`timescale 1ns / 1ps

module gmig_queue
  import gmig_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hdl/gmig_back.sv
`timescale 1ns / 1ps

module gmig_back
  import gmig_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  cmd_t                   head_cmd,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  // Working copy of the cell being emitted.
  logic [VTX_W-1:0] a_r, d_r, e_r, g_r;
  logic             lm_r, tm_r, lastg_r;
  logic             busy_r, busy_nxt;
  slot_t            slot_r, slot_nxt;

  logic             ov_r, ov_nxt;
  logic [VTX_W-1:0] first_r, second_r, third_r;
  logic             tlast_r, tuser_r;

  logic             adv, emit, final_slot;
  logic [VTX_W-1:0] p, q;
  slot_t            slot_step;

  assign adv        = !ov_r || out_tready;
  assign emit       = busy_r && adv;
  assign final_slot = (slot_r == S_HG);
  assign pop        = head_valid && (!busy_r || (emit && final_slot));

  // Outer corners of the current triangle and the slot that follows it.
  always_comb begin
    unique case (slot_r)
      S_GD: begin
        p = g_r;
        q = lm_r ? a_r : d_r;
        slot_step = lm_r ? S_AB : S_DA;
      end
      S_DA: begin
        p = d_r;
        q = a_r;
        slot_step = S_AB;
      end
      S_AB: begin
        p = a_r;
        q = tm_r ? a_r + VTX_W'(2) : a_r + VTX_W'(1);
        slot_step = tm_r ? S_CF : S_BC;
      end
      S_BC: begin
        p = a_r + VTX_W'(1);
        q = a_r + VTX_W'(2);
        slot_step = S_CF;
      end
      S_CF: begin
        p = a_r + VTX_W'(2);
        q = d_r + VTX_W'(2);
        slot_step = S_FI;
      end
      S_FI: begin
        p = d_r + VTX_W'(2);
        q = g_r + VTX_W'(2);
        slot_step = S_IH;
      end
      S_IH: begin
        p = g_r + VTX_W'(2);
        q = g_r + VTX_W'(1);
        slot_step = S_HG;
      end
      S_HG: begin
        p = g_r + VTX_W'(1);
        q = g_r;
        slot_step = S_GD;
      end
      default: begin
        p = g_r;
        q = d_r;
        slot_step = S_GD;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    if (pop) begin
      busy_nxt = 1'b1;
      slot_nxt = S_GD;
    end else if (emit) begin
      slot_nxt = slot_step;
      if (final_slot) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= S_GD;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_r     <= head_cmd.base;
      d_r     <= head_cmd.base + VTX_W'(head_cmd.row_len);
      e_r     <= head_cmd.base + VTX_W'(head_cmd.row_len) + VTX_W'(1);
      g_r     <= head_cmd.base + VTX_W'({head_cmd.row_len, 1'b0});
      lm_r    <= head_cmd.left_merge;
      tm_r    <= head_cmd.top_merge;
      lastg_r <= head_cmd.last_cell;
    end
    if (emit) begin
      first_r  <= e_r;
      second_r <= q;
      third_r  <= p;
      tlast_r  <= final_slot;
      tuser_r  <= final_slot && lastg_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {(OUT_TDATA_W - 3*VTX_W)'(0), third_r, second_r, first_r};
  assign out_tlast  = tlast_r;
  assign out_tuser  = tuser_r;

endmodule

### sim/grid_mesh_index_generator_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the grid mesh index generator.
// A short table of directed words and register writes runs first. Each table row
// is checked either against a triangle typed into the table or against the
// in-bench fan predictor. A long walk then drives a tall, narrow grid down to
// its bottom row. The bench then widens the grid, so that vertex indices above
// 2^16 appear. Random phases with random grid settings follow. Both stream sides
// idle at random.

module grid_mesh_index_generator_test;
  import gmig_pkg::*;

  localparam int MAX_SIDE      = MAX_SIDE_DEFAULT;
  localparam int ITEM_TARGET   = 310;
  localparam int SETTLE_CYCLES = 16;      // a cell yields at most eight triangles
  localparam int HOLD_CYCLES   = 300;     // long output stall that fills the cell queue
  localparam int CYCLE_LIMIT   = 400000;

  // The register map has no name for the spare variant code; it stitches like the
  // edge mode.
  localparam logic [VAR_W-1:0] VARIANT_SPARE = 2'd3;

  // One triangle as it leaves the block: the cell center first, then the two
  // outer corners in emitted order.
  typedef struct packed {
    logic [VTX_W-1:0] v_first;
    logic [VTX_W-1:0] v_second;
    logic [VTX_W-1:0] v_third;
    logic             last_cell;
    logic             last_grid;
  } facet_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  // A row of the directed table. A word row can carry its first triangle typed
  // in by hand. That triangle then replaces the predicted one.
  typedef struct {
    row_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [SIDE_W-1:0] value;
    logic              restart;
    bit                typed;
    facet_t            first_facet;
  } step_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_wr_en;
  logic [IDX_W-1:0]       cfg_index;
  logic [SIDE_W-1:0]      cfg_wdata;

  grid_mesh_index_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mirror of the registers and of the walk position. The walk position is the
  // next cell to emit.
  logic [SIDE_W-1:0] cfg_width   = SIDE_RESET;
  logic [SIDE_W-1:0] cfg_height  = SIDE_RESET;
  logic [VAR_W-1:0]  cfg_variant = VARIANT_NORMAL;
  int unsigned       cell_col    = 0;
  int unsigned       cell_row    = 0;

  facet_t      facet_q[$];        // triangles owed by the block, oldest first
  step_t       plan[$];
  int          errors       = 0;
  int          words_sent   = 0;
  int          reg_writes   = 0;
  int          facets_seen  = 0;
  int          grid_ends    = 0;
  int unsigned peak_index   = 0;
  int          cycle_count  = 0;
  bit          in_quiet     = 1'b0;
  bit          out_quiet    = 1'b0;
  bit          hold_request = 1'b0;

  // The block clamps a side to [2, MAX_SIDE] and then drops the low bit.
  function automatic int unsigned even_side(logic [SIDE_W-1:0] v);
    int unsigned s;
    s = 32'(v);
    if (s < 2) s = 2;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s & ~32'd1;
  endfunction

  // Triangle (center, p, q) leaves the block as center, q, p.
  function automatic facet_t fan_facet(int unsigned ctr, int unsigned p, int unsigned q);
    facet_t f;
    f.v_first   = ctr[VTX_W-1:0];
    f.v_second  = q[VTX_W-1:0];
    f.v_third   = p[VTX_W-1:0];
    f.last_cell = 1'b0;
    f.last_grid = 1'b0;
    return f;
  endfunction

  // Works out the fan of the current cell. It queues the triangles and steps the
  // walk. The return value is the number of triangles.
  function automatic int predict_cell(logic restart);
    int unsigned gw, gh, cols, rows, vc;
    int unsigned a, b, c, d, e, f, g, h, i;
    bit          left_m, top_m, grid_end;
    facet_t      fan[8];
    int          n;
    gw   = even_side(cfg_width);
    gh   = even_side(cfg_height);
    cols = gw / 2;
    rows = gh / 2;
    vc   = gw + 1;
    n    = 0;
    // An explicit restart and a stale position outside a shrunken grid both
    // send the walk back to the first cell.
    if (restart || cell_col >= cols || cell_row >= rows) begin
      cell_col = 0;
      cell_row = 0;
    end
    a = cell_row * 2 * vc + cell_col * 2;
    b = a + 1;
    c = a + 2;
    d = a + vc;
    e = a + vc + 1;
    f = a + vc + 2;
    g = a + 2 * vc;
    h = a + 2 * vc + 1;
    i = a + 2 * vc + 2;
    left_m = (cell_col == 0) && (cfg_variant != VARIANT_NORMAL);
    top_m  = (cell_row == 0) && (cfg_variant == VARIANT_CORNER);
    if (left_m) begin
      fan[n] = fan_facet(e, g, a);
      n++;
    end else begin
      fan[n] = fan_facet(e, g, d);
      n++;
      fan[n] = fan_facet(e, d, a);
      n++;
    end
    if (top_m) begin
      fan[n] = fan_facet(e, a, c);
      n++;
    end else begin
      fan[n] = fan_facet(e, a, b);
      n++;
      fan[n] = fan_facet(e, b, c);
      n++;
    end
    fan[n] = fan_facet(e, c, f);
    n++;
    fan[n] = fan_facet(e, f, i);
    n++;
    fan[n] = fan_facet(e, i, h);
    n++;
    fan[n] = fan_facet(e, h, g);
    n++;
    grid_end = (cell_col + 1 == cols) && (cell_row + 1 == rows);
    fan[n-1].last_cell = 1'b1;
    fan[n-1].last_grid = grid_end;
    for (int k = 0; k < n; k++) facet_q = {facet_q, fan[k]};
    if (grid_end) begin
      cell_col = 0;
      cell_row = 0;
    end else if (cell_col + 1 >= cols) begin
      cell_col = 0;
      cell_row++;
    end else begin
      cell_col++;
    end
    return n;
  endfunction

  function automatic void add_word(logic restart);
    step_t s;
    s.kind        = ROW_WORD;
    s.idx         = REG_GRID_WIDTH;
    s.value       = '0;
    s.restart     = restart;
    s.typed       = 1'b0;
    s.first_facet = '0;
    plan = {plan, s};
  endfunction

  function automatic void add_typed(logic restart, int unsigned v1, int unsigned v2,
                                    int unsigned v3);
    step_t s;
    s.kind        = ROW_WORD;
    s.idx         = REG_GRID_WIDTH;
    s.value       = '0;
    s.restart     = restart;
    s.typed       = 1'b1;
    s.first_facet = '{v1[VTX_W-1:0], v2[VTX_W-1:0], v3[VTX_W-1:0], 1'b0, 1'b0};
    plan = {plan, s};
  endfunction

  function automatic void add_reg(logic [IDX_W-1:0] idx, logic [SIDE_W-1:0] value);
    step_t s;
    s.kind        = ROW_REG;
    s.idx         = idx;
    s.value       = value;
    s.restart     = 1'b0;
    s.typed       = 1'b0;
    s.first_facet = '0;
    plan = {plan, s};
  endfunction

  // Sizes are mostly small, so that grid ends come often. Now and then a size is
  // drawn over the whole register, which takes in the clamped values.
  function automatic logic [SIDE_W-1:0] pick_side();
    if ($urandom_range(0, 9) < 7) return SIDE_W'($urandom_range(0, 12));
    return SIDE_W'($urandom_range(0, 511));
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Offers one word after a random gap. The valid stays high when no gap
  // follows, so that words can go back to back. The prediction is made at the
  // edge that accepts the word.
  task automatic send_word(logic restart, bit typed, facet_t typed_first);
    int gap;
    int n;
    if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(restart);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n = predict_cell(restart);
    if (typed) facet_q[facet_q.size() - n] = typed_first;
    words_sent++;
  endtask

  // Registers change only once the block has delivered every owed triangle and
  // has then had time to settle.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [SIDE_W-1:0] value);
    in_tvalid <= 1'b0;
    while (facet_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:   cfg_width   = value;
      REG_GRID_HEIGHT:  cfg_height  = value;
      REG_TILE_VARIANT: cfg_variant = value[VAR_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // The run ends by force if a result never arrives.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side. Each word gets its own random stall. Once during the run, a long
  // stall backs the block up into its input.
  initial begin : result_sink
    int     hold;
    facet_t want;
    facet_t got;
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) out_quiet = !out_quiet;
      hold = out_quiet ? 0 : $urandom_range(0, 9);
      if (hold_request) begin
        hold         = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.v_first   = out_tdata[VTX_W-1:0];
      got.v_second  = out_tdata[2*VTX_W-1:VTX_W];
      got.v_third   = out_tdata[3*VTX_W-1:2*VTX_W];
      got.last_cell = out_tlast;
      got.last_grid = out_tuser;
      if (got.v_first > peak_index) peak_index = 32'(got.v_first);
      if (got.v_second > peak_index) peak_index = 32'(got.v_second);
      if (got.v_third > peak_index) peak_index = 32'(got.v_third);
      if (facet_q.size() == 0) begin
        $error("unexpected output word: %0d %0d %0d last_in_cell %0b last_in_grid %0b",
               got.v_first, got.v_second, got.v_third, got.last_cell, got.last_grid);
        errors++;
      end else begin
        want = facet_q.pop_front();
        check_field("vertex_first", 32'(want.v_first), 32'(got.v_first));
        check_field("vertex_second", 32'(want.v_second), 32'(got.v_second));
        check_field("vertex_third", 32'(want.v_third), 32'(got.v_third));
        check_field("last_in_cell", 32'(want.last_cell), 32'(got.last_cell));
        check_field("last_in_grid", 32'(want.last_grid), 32'(got.last_grid));
        if (want.last_grid) grid_ends++;
        facets_seen++;
      end
    end
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_GRID_WIDTH;
    cfg_wdata = '0;

    // Directed table. After reset the grid is 2 by 2 with one cell, so its center
    // is vertex 4 and the first triangle runs 4, 3, 6.
    add_typed(1'b0, 4, 3, 6);
    add_typed(1'b1, 4, 3, 6);
    add_word(1'b0);
    // Six cells on a 6 by 4 grid: the walk crosses a row, ends the grid, wraps,
    // and is then restarted in the middle.
    add_reg(REG_GRID_WIDTH, 9'd6);
    add_reg(REG_GRID_HEIGHT, 9'd4);
    repeat (6) add_word(1'b0);
    add_word(1'b0);
    add_word(1'b1);
    add_reg(REG_TILE_VARIANT, SIDE_W'(VARIANT_EDGE));
    repeat (3) add_word(1'b0);
    // Corner stitching. The first cell merges left and top, so it opens with
    // center 8, top-left 0 and bottom-left 14.
    add_reg(REG_TILE_VARIANT, SIDE_W'(VARIANT_CORNER));
    add_typed(1'b1, 8, 0, 14);
    repeat (3) add_word(1'b0);
    add_reg(REG_TILE_VARIANT, SIDE_W'(VARIANT_SPARE));
    repeat (2) add_word(1'b0);
    // Oversized and undersized sides clamp to 256 and 2. The vertex row is then
    // 257 long.
    add_reg(REG_GRID_WIDTH, 9'd511);
    add_reg(REG_GRID_HEIGHT, 9'd1);
    add_reg(REG_TILE_VARIANT, SIDE_W'(VARIANT_CORNER));
    add_typed(1'b1, 258, 0, 514);
    add_word(1'b0);
    // The width shrinks under a walk that stands at column two. The next word
    // must come from the first cell.
    add_reg(REG_GRID_WIDTH, 9'd3);
    add_word(1'b0);
    add_reg(REG_GRID_WIDTH, 9'd0);
    add_reg(REG_GRID_HEIGHT, 9'd0);
    add_reg(REG_TILE_VARIANT, SIDE_W'(VARIANT_SPARE));
    add_typed(1'b1, 4, 0, 6);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_REG) begin
        write_reg(plan[k].idx, plan[k].value);
      end else begin
        send_word(plan[k].restart, plan[k].typed, plan[k].first_facet);
      end
    end

    // Long walk. With one cell per row, 127 words bring the walk to the bottom
    // row of a 2 by 256 grid. Widening the grid there keeps the position and
    // pushes the indices past 2^16. The long output stall is asked for at the
    // start of the walk.
    write_reg(REG_GRID_WIDTH, 9'd2);
    write_reg(REG_GRID_HEIGHT, 9'd256);
    write_reg(REG_TILE_VARIANT, SIDE_W'($urandom_range(0, 3)));
    hold_request = 1'b1;
    send_word(1'b1, 1'b0, '0);
    repeat (126) send_word(1'b0, 1'b0, '0);
    write_reg(REG_GRID_WIDTH, 9'd256);
    repeat (4) send_word(1'b0, 1'b0, '0);

    // Random phases. Each phase is a fresh mix of register values. A run of
    // words walks the grid under that mix, with an occasional restart.
    while (words_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 1)) write_reg(REG_GRID_WIDTH, pick_side());
      if ($urandom_range(0, 1)) write_reg(REG_GRID_HEIGHT, pick_side());
      if ($urandom_range(0, 1)) write_reg(REG_TILE_VARIANT, SIDE_W'($urandom_range(0, 511)));
      repeat ($urandom_range(4, 24)) send_word($urandom_range(0, 7) == 0, 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (facet_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d cell words and %0d register writes; checked %0d triangles.",
             words_sent, reg_writes, facets_seen);
    $display("Saw %0d grid ends; the highest vertex index was %0d.", grid_ends, peak_index);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
